FILE: rtl/msog_pkg.sv
`timescale 1ns / 1ps

package msog_pkg;

   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CNT_W-1:0] STALL_DECAY_STEP = 16'd1;
   localparam logic signed [15:0] RECIP_MIN_SPEED_SET = 16'sd100;

   localparam logic [2:0] MODE_RECIP = 3'd3;
   localparam logic [2:0] MODE_SKIP_A = 3'd4;
   localparam logic [2:0] MODE_SKIP_B = 3'd5;

   localparam logic [1:0] FB_SENSORLESS = 2'd1;
   localparam logic [1:0] FB_HALL = 2'd2;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_STALL = 2'd1,
      FAULT_OC    = 2'd2
   } fault_type;

   typedef enum logic [2:0] {
      CSR_STALL_SPEED_LIMIT    = 3'd0,
      CSR_STALL_COUNT_LIMIT    = 3'd1,
      CSR_OC_THRESHOLD         = 3'd2,
      CSR_OC_LIMIT_HALL_ONEWAY = 3'd3,
      CSR_OC_LIMIT_HALL_RECIP  = 3'd4,
      CSR_OC_LIMIT_SENSORLESS  = 3'd5,
      CSR_LONG_OC_THRESHOLD    = 3'd6,
      CSR_LONG_OC_COUNT_LIMIT  = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic adv;
      logic clr;
      logic hold;
      logic cond;
   } leaky_ctl_type;

endpackage

FILE: rtl/msog_leaky_cnt.sv
`timescale 1ns / 1ps

module msog_leaky_cnt
   import msog_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  leaky_ctl_type    ctl,
   input  logic [CNT_W-1:0] limit,
   output logic             trip
);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] cnt_up;
   logic             over;

   assign cnt_up = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign over   = cnt_up > limit;
   assign trip   = ctl.adv && !ctl.clr && !ctl.hold && ctl.cond && over;

   always_comb begin
      priority if (ctl.clr) begin
         cnt_in = '0;
      end else if (ctl.hold) begin
         cnt_in = cnt_ff;
      end else if (ctl.cond) begin
         cnt_in = over ? '0 : cnt_up;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.adv) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/motor_stall_overcurrent_guard_core.sv
`timescale 1ns / 1ps

// Stall and overcurrent guard for one motor channel. Each req_ item is one
// protection check tick; it yields exactly one rsp_ item carrying the latched
// fault code and a flag that some counter tripped on that tick. The block
// takes one item per clock cycle while rsp_ is not stalled; a result passes
// through the input register, then the counter update and result register.
// The four leaky counters are all read and written on every tick. Backpressure
// on rsp_ holds the result and then the input register; the latched fault
// clears only on reset.

module motor_stall_overcurrent_guard_core
   import msog_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // running[0], speed_now[16:1], speed_set[32:17], total_current[48:33],
   // at_position_brake[49], recip_channel_selected[50], zero[55:51]
   input  logic [55:0] req_tdata,
   // control_mode[2:0], feedback_kind[4:3]
   input  logic [4:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fault_code[1:0], fault_raised[2], zero[7:3]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // configuration
   logic [14:0] stall_speed_limit_ff;
   logic [15:0] stall_count_limit_ff;
   logic [15:0] oc_threshold_ff;
   logic [15:0] oc_limit_hall_oneway_ff;
   logic [15:0] oc_limit_hall_recip_ff;
   logic [15:0] oc_limit_sensorless_ff;
   logic [15:0] long_oc_threshold_ff;
   logic [15:0] long_oc_count_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_speed_limit_ff    <= 15'd0;
         stall_count_limit_ff    <= 16'd100;
         oc_threshold_ff         <= 16'hFFFF;
         oc_limit_hall_oneway_ff <= 16'd100;
         oc_limit_hall_recip_ff  <= 16'd100;
         oc_limit_sensorless_ff  <= 16'd100;
         long_oc_threshold_ff    <= 16'hFFFF;
         long_oc_count_limit_ff  <= 16'd1000;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_STALL_SPEED_LIMIT:    stall_speed_limit_ff    <= csr_wdata[14:0];
            CSR_STALL_COUNT_LIMIT:    stall_count_limit_ff    <= csr_wdata;
            CSR_OC_THRESHOLD:         oc_threshold_ff         <= csr_wdata;
            CSR_OC_LIMIT_HALL_ONEWAY: oc_limit_hall_oneway_ff <= csr_wdata;
            CSR_OC_LIMIT_HALL_RECIP:  oc_limit_hall_recip_ff  <= csr_wdata;
            CSR_OC_LIMIT_SENSORLESS:  oc_limit_sensorless_ff  <= csr_wdata;
            CSR_LONG_OC_THRESHOLD:    long_oc_threshold_ff    <= csr_wdata;
            CSR_LONG_OC_COUNT_LIMIT:  long_oc_count_limit_ff  <= csr_wdata;
            default:                  stall_speed_limit_ff    <= stall_speed_limit_ff;
         endcase
      end
   end

   // input register
   logic               s1_valid_ff;
   logic               s1_adv;
   logic               running_ff;
   logic [2:0]         mode_ff;
   logic [1:0]         fb_ff;
   logic signed [15:0] speed_now_ff;
   logic signed [15:0] speed_set_ff;
   logic [15:0]        current_ff;
   logic               brake_ff;
   logic               sel_ff;

   logic out_free;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         running_ff   <= req_tdata[0];
         speed_now_ff <= req_tdata[16:1];
         speed_set_ff <= req_tdata[32:17];
         current_ff   <= req_tdata[48:33];
         brake_ff     <= req_tdata[49];
         sel_ff       <= req_tdata[50];
         mode_ff      <= req_tuser[2:0];
         fb_ff        <= req_tuser[4:3];
      end
   end

   // check logic
   logic [16:0] speed_mag;
   logic        slow;
   logic        main_on;
   logic        fb_valid;
   logic        is_recip;
   logic [15:0] oc_limit;

   assign speed_mag = speed_now_ff[15] ? 17'(-{speed_now_ff[15], speed_now_ff})
                                       : {1'b0, speed_now_ff};
   assign slow      = speed_mag < {2'b00, stall_speed_limit_ff};
   assign is_recip  = mode_ff == MODE_RECIP;
   assign main_on   = running_ff && !brake_ff && mode_ff != MODE_SKIP_A
                      && mode_ff != MODE_SKIP_B;
   assign fb_valid  = fb_ff == FB_HALL || fb_ff == FB_SENSORLESS;

   always_comb begin
      priority if (fb_ff == FB_SENSORLESS) begin
         oc_limit = oc_limit_sensorless_ff;
      end else if (is_recip) begin
         oc_limit = oc_limit_hall_recip_ff;
      end else begin
         oc_limit = oc_limit_hall_oneway_ff;
      end
   end

   leaky_ctl_type stall_ctl;
   leaky_ctl_type oc_ctl;
   leaky_ctl_type long_ctl;
   logic          stall_trip;
   logic          oc_trip;
   logic          long_trip;

   assign stall_ctl = '{adv: s1_adv, clr: !main_on, hold: 1'b0, cond: slow && !is_recip};
   assign oc_ctl    = '{adv: s1_adv, clr: !main_on, hold: !fb_valid,
                        cond: current_ff > oc_threshold_ff};
   assign long_ctl  = '{adv: s1_adv, clr: !main_on, hold: 1'b0,
                        cond: current_ff > long_oc_threshold_ff};

   msog_leaky_cnt u_stall_cnt (
      .clock (clock),
      .reset (reset),
      .ctl   (stall_ctl),
      .limit (stall_count_limit_ff),
      .trip  (stall_trip)
   );

   msog_leaky_cnt u_oc_cnt (
      .clock (clock),
      .reset (reset),
      .ctl   (oc_ctl),
      .limit (oc_limit),
      .trip  (oc_trip)
   );

   msog_leaky_cnt u_long_oc_cnt (
      .clock (clock),
      .reset (reset),
      .ctl   (long_ctl),
      .limit (long_oc_count_limit_ff),
      .trip  (long_trip)
   );

   // reciprocating stall counter
   logic [CNT_W-1:0] recip_cnt_ff;
   logic [CNT_W-1:0] recip_cnt_in;
   logic [CNT_W-1:0] recip_up;
   logic             recip_cond;
   logic             recip_over;
   logic             recip_trip;

   assign recip_cond = slow && is_recip && (speed_set_ff >= RECIP_MIN_SPEED_SET)
                       && sel_ff && running_ff && !brake_ff;
   assign recip_up   = (recip_cnt_ff == CNT_MAX) ? recip_cnt_ff
                                                 : recip_cnt_ff + CNT_W'(1);
   assign recip_over = recip_up > stall_count_limit_ff;
   assign recip_trip = s1_adv && recip_cond && recip_over;

   always_comb begin
      priority if (recip_cond) begin
         recip_cnt_in = recip_over ? '0 : recip_up;
      end else if (recip_cnt_ff > STALL_DECAY_STEP) begin
         recip_cnt_in = recip_cnt_ff - STALL_DECAY_STEP;
      end else begin
         recip_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_cnt_ff <= '0;
      end else if (s1_adv) begin
         recip_cnt_ff <= recip_cnt_in;
      end
   end

   // latched fault: later checks override earlier ones
   fault_type latched_ff;
   fault_type latched_in;
   logic      raised;

   assign raised = stall_trip || oc_trip || long_trip || recip_trip;

   always_comb begin
      priority if (long_trip || recip_trip) begin
         latched_in = FAULT_STALL;
      end else if (oc_trip) begin
         latched_in = FAULT_OC;
      end else if (stall_trip) begin
         latched_in = FAULT_STALL;
      end else begin
         latched_in = latched_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= FAULT_NONE;
      end else if (s1_adv) begin
         latched_ff <= latched_in;
      end
   end

   // result register
   logic       rsp_valid_ff;
   logic [1:0] rsp_code_ff;
   logic       rsp_raised_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_code_ff   <= latched_in;
         rsp_raised_ff <= raised;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_raised_ff, rsp_code_ff};

`ifndef SYNTH
   a_raised_has_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_raised_ff |-> rsp_code_ff != FAULT_NONE)
      else $error("fault raised with no code");

   a_latch_sticky : assert property (@(posedge clock) disable iff (reset)
      latched_ff != FAULT_NONE |=> latched_ff != FAULT_NONE)
      else $error("latched fault cleared without reset");

   a_stalled_input : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_tready)
      else $error("item accepted over a held input register");

   a_recip_hold : assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(recip_cnt_ff))
      else $error("recip counter moved without an item");
`endif

endmodule
